FILE: rtl/core/mwsm_pkg.sv
package mwsm_pkg;

  // Default width of the velocity and wheel speed fields.
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // Number of wheels, one lane each.
  localparam int unsigned WHEELS = 4;

  // Width of max_output and min_output, and of the scaled quotient.
  localparam int unsigned LIM_W = 15;

  // Width of the yaw gain (unsigned Q8.8).
  localparam int unsigned YAW_W = 16;

  // Configuration port widths.
  localparam int unsigned CFG_W = 16;
  localparam int unsigned IDX_W = 3;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_SQUARE = 3'd0;
  localparam logic [IDX_W-1:0] REG_YAW    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN    = 3'd3;

  // Register reset values.
  localparam logic             SQUARE_RST = 1'b0;
  localparam logic [YAW_W-1:0] YAW_RST    = 16'd256;
  localparam logic [LIM_W-1:0] MAX_RST    = 15'd32767;
  localparam logic [LIM_W-1:0] MIN_RST    = 15'd0;

endpackage

FILE: rtl/core/mecanum_wheel_speed_mixer_top.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   vel_x_i, vel_y_i, vel_rot_i
// out      output     out_valid_o / out_stall_i wheel_0_speed_o .. wheel_3_speed_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One beat is accepted per cycle while in_stall_o is low; a beat passes s1_q, s2_q, s3_q,
// the divider registers dv_q (one quotient bit per stage, fifteen stages) and out_q.
// Reset loads the configuration registers with their reset values and clears all valid bits.
// The output register is backed by one skid register; in_stall_o is high while it holds a beat.
// A stall freezes the whole pipeline, so no beat is lost or repeated.
module mecanum_wheel_speed_mixer_top #(
  parameter int unsigned VALUE_WIDTH = mwsm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [mwsm_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [mwsm_pkg::CFG_W-1:0]        cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0]     vel_x_i,
  input  logic signed [VALUE_WIDTH-1:0]     vel_y_i,
  input  logic signed [VALUE_WIDTH-1:0]     vel_rot_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]     wheel_0_speed_o,
  output logic signed [VALUE_WIDTH-1:0]     wheel_1_speed_o,
  output logic signed [VALUE_WIDTH-1:0]     wheel_2_speed_o,
  output logic signed [VALUE_WIDTH-1:0]     wheel_3_speed_o
);

  // Widths. The linear terms need two extra bits, the yaw product seventeen,
  // and the Q.8 wheel sums one more than the wider of the two.
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned PW = VW + 2;
  localparam int unsigned RW = VW + mwsm_pkg::YAW_W + 1;
  localparam int unsigned SW = RW + 1;
  localparam int unsigned MW = SW;
  localparam int unsigned QB = mwsm_pkg::LIM_W;
  localparam int unsigned NW = MW + QB;
  localparam int unsigned LW = MW - 8;
  localparam int unsigned NL = mwsm_pkg::WHEELS;
  localparam int unsigned ND = QB;
  localparam int unsigned NS = ND + 4;

  typedef struct packed {
    logic [NL-1:0][PW-1:0] p;
    logic [RW-1:0]         rot;
  } s1_t;

  typedef struct packed {
    logic [NL-1:0]         neg;
    logic [NL-1:0][MW-1:0] mag;
  } s2_t;

  typedef struct packed {
    logic [NL-1:0]         neg;
    logic [NL-1:0][MW-1:0] mag;
    logic [MW-1:0]         m;
  } s3_t;

  typedef struct packed {
    logic                  scale;
    logic [MW-1:0]         m;
    logic [NL-1:0]         neg;
    logic [NL-1:0][NW-1:0] rem;
    logic [NL-1:0][QB-1:0] quo;
    logic [NL-1:0][LW-1:0] low;
  } dv_t;

  // Configuration registers.
  logic                          sq_q;
  logic [mwsm_pkg::YAW_W-1:0]    yaw_q;
  logic [QB-1:0]                 max_q;
  logic [QB-1:0]                 min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q  <= mwsm_pkg::SQUARE_RST;
      yaw_q <= mwsm_pkg::YAW_RST;
      max_q <= mwsm_pkg::MAX_RST;
      min_q <= mwsm_pkg::MIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mwsm_pkg::REG_SQUARE: begin
          sq_q <= cfg_data_i[0];
        end
        mwsm_pkg::REG_YAW: begin
          yaw_q <= cfg_data_i[mwsm_pkg::YAW_W-1:0];
        end
        mwsm_pkg::REG_MAX: begin
          max_q <= cfg_data_i[QB-1:0];
        end
        mwsm_pkg::REG_MIN: begin
          min_q <= cfg_data_i[QB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline advances unless the skid register holds a beat.
  logic          adv;
  logic [NS-1:0] v_q;
  logic          out_v_q;
  logic          skid_v_q;
  logic          out_take;
  logic          last_v;

  assign adv      = !skid_v_q;
  assign out_take = out_v_q && !out_stall_i;
  assign last_v   = v_q[NS-1];

  // Stage one: the linear x and y terms of each wheel and the yaw product.
  s1_t                  s1_d, s1_q;
  logic signed [VW:0]   xe, sx;
  logic signed [PW-1:0] sxe, ye;

  always_comb begin
    xe  = {vel_x_i[VW-1], vel_x_i};
    sx  = sq_q ? -xe : xe;
    sxe = {sx[VW], sx};
    ye  = {{2{vel_y_i[VW-1]}}, vel_y_i};
    s1_d.p[0] = -sxe + ye;
    s1_d.p[1] = -sxe - ye;
    s1_d.p[2] = sxe - ye;
    s1_d.p[3] = sxe + ye;
    s1_d.rot  = RW'($signed({1'b0, yaw_q})) * RW'(vel_rot_i);
  end

  // Stage two: the exact Q.8 wheel values, split into sign and magnitude.
  s2_t            s2_d, s2_q;
  logic [SW-1:0]  wsum [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      wsum[k] = {{(SW-PW-8){s1_q.p[k][PW-1]}}, s1_q.p[k], 8'b0}
              + {{(SW-RW){s1_q.rot[RW-1]}}, s1_q.rot};
      s2_d.neg[k] = wsum[k][SW-1];
      s2_d.mag[k] = wsum[k][SW-1] ? (~wsum[k] + SW'(1)) : wsum[k];
    end
  end

  // Stage three: the largest magnitude over the four wheels.
  s3_t           s3_d, s3_q;
  logic [MW-1:0] mx01, mx23;

  always_comb begin
    mx01     = (s2_q.mag[0] > s2_q.mag[1]) ? s2_q.mag[0] : s2_q.mag[1];
    mx23     = (s2_q.mag[2] > s2_q.mag[3]) ? s2_q.mag[2] : s2_q.mag[3];
    s3_d.neg = s2_q.neg;
    s3_d.mag = s2_q.mag;
    s3_d.m   = (mx01 > mx23) ? mx01 : mx23;
  end

  // Stage four: dividends for the scaled path and the scale decision.
  // Since every magnitude is at most m, the quotient fits in QB bits.
  // Behind it, a restoring divider, one quotient bit per stage, most significant first.
  dv_t           dv_d [ND+1];
  dv_t           dv_q [ND+1];
  logic [NW-1:0] dsh  [ND];

  always_comb begin
    dv_d[0].scale = s3_q.m > MW'({max_q, 8'b0});
    dv_d[0].m     = s3_q.m;
    dv_d[0].neg   = s3_q.neg;
    for (int k = 0; k < NL; k++) begin
      dv_d[0].rem[k] = {{QB{1'b0}}, s3_q.mag[k]} * {{MW{1'b0}}, max_q};
      dv_d[0].quo[k] = '0;
      dv_d[0].low[k] = s3_q.mag[k][MW-1:8];
    end
    for (int j = 0; j < ND; j++) begin
      dsh[j]    = {{QB{1'b0}}, dv_q[j].m} << (ND - 1 - j);
      dv_d[j+1] = dv_q[j];
      for (int k = 0; k < NL; k++) begin
        if (dv_q[j].rem[k] >= dsh[j]) begin
          dv_d[j+1].rem[k]             = dv_q[j].rem[k] - dsh[j];
          dv_d[j+1].quo[k][ND - 1 - j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      for (int i = 0; i <= ND; i++) begin
        dv_q[i] <= dv_d[i];
      end
    end
  end

  // Result: pick the scaled quotient or the plain truncated value, apply the
  // deadband and the sign, and keep the low VW bits.
  logic [NL-1:0][LW-1:0] vmag;
  logic [NL-1:0][LW-1:0] vsgn;
  logic [NL-1:0][VW-1:0] res;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      vmag[k] = dv_q[ND].scale ? {{(LW-QB){1'b0}}, dv_q[ND].quo[k]} : dv_q[ND].low[k];
      vsgn[k] = dv_q[ND].neg[k] ? (~vmag[k] + LW'(1)) : vmag[k];
      res[k]  = (vmag[k] < LW'(min_q)) ? '0 : vsgn[k][VW-1:0];
    end
  end

  // Output register with a skid register behind it.
  logic [NL-1:0][VW-1:0] out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= last_v;
      end
    end else if (adv && last_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (adv && last_v) begin
      skid_q <= res;
    end
  end

  assign in_stall_o      = !adv;
  assign out_valid_o     = out_v_q;
  assign wheel_0_speed_o = out_q[0];
  assign wheel_1_speed_o = out_q[1];
  assign wheel_2_speed_o = out_q[2];
  assign wheel_3_speed_o = out_q[3];

`ifndef ASSERT_OFF
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && skid_v_q) |=> (out_v_q && !skid_v_q))
    else $error("skid beat was not moved into the output register");

  a_quo_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_v && dv_q[ND].scale) |-> (dv_q[ND].quo[0] <= max_q))
    else $error("scaled wheel speed exceeds max_output");
`endif

endmodule
